@@ hw/rtl/dnm_pkg.sv @@
// Shared types, constants and helper functions for the DNA needle matcher.
// Used by dnm_cfg and dna_needle_matcher; depends on nothing else.

package dnm_pkg;

    localparam int MAX_NEEDLE = 32;
    localparam int BASE_W     = 2;
    localparam int WIN_W      = BASE_W * MAX_NEEDLE;
    localparam int LEN_W      = 6;
    localparam int CNT_W      = 40;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 64;
    localparam int SHIFT_W    = $clog2(WIN_W) + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register index, taken from the 8-byte-aligned address bit.
    typedef enum logic [0:0] {
        REG_NEEDLE_CODES  = 1'b0,
        REG_NEEDLE_LENGTH = 1'b1
    } reg_idx_t;

    // Needle laid out the way the base window holds bases, plus compare masks.
    typedef struct packed {
        logic [WIN_W-1:0]      target;
        logic [WIN_W-1:0]      base_mask;
        logic [MAX_NEEDLE-1:0] brk_mask;
        logic                  len_ok;
        logic [LEN_W-1:0]      len;
    } match_cfg_t;

    // Window slot i (i = 0 newest) must hold needle base len-1-i.
    function automatic logic [WIN_W-1:0] needle_target(logic [WIN_W-1:0] codes,
                                                       logic [LEN_W-1:0] len);
        logic [WIN_W-1:0]   rev;
        logic [SHIFT_W-1:0] sh;
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            rev[BASE_W*i +: BASE_W] = codes[BASE_W*(MAX_NEEDLE-1-i) +: BASE_W];
        end
        sh = SHIFT_W'(BASE_W * (MAX_NEEDLE - int'(len)));
        return rev >> sh;
    endfunction

    function automatic match_cfg_t build_cfg(logic [WIN_W-1:0] codes,
                                             logic [LEN_W-1:0] len);
        match_cfg_t c;
        for (int i = 0; i < MAX_NEEDLE; i++) begin
            c.brk_mask[i]                    = (i < int'(len));
            c.base_mask[BASE_W*i +: BASE_W]  = {BASE_W{(i < int'(len))}};
        end
        c.target = needle_target(codes, len);
        c.len_ok = (len != '0) && (int'(len) <= MAX_NEEDLE);
        c.len    = len;
        return c;
    endfunction

endpackage

@@ hw/rtl/dnm_cfg.sv @@
// APB-style configuration registers of the DNA needle matcher.
// Holds the needle and its length and registers the derived compare setup; uses dnm_pkg.

module dnm_cfg import dnm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output match_cfg_t        cfg
);

    logic [WIN_W-1:0] needle_codes_reg;
    logic [LEN_W-1:0] needle_length_reg;
    match_cfg_t       cfg_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = reg_idx_t'(paddr[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_codes_reg  <= '0;
            needle_length_reg <= LEN_W'(1);
            cfg_reg           <= build_cfg('0, LEN_W'(1));
        end else begin
            if (wr_en) begin
                unique case (idx)
                    REG_NEEDLE_CODES:  needle_codes_reg  <= pwdata[WIN_W-1:0];
                    REG_NEEDLE_LENGTH: needle_length_reg <= pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            // The derived setup follows a write in the next cycle, well inside idle time.
            cfg_reg <= build_cfg(needle_codes_reg, needle_length_reg);
        end
    end

    always_comb begin
        unique case (idx)
            REG_NEEDLE_CODES:  prdata = DATA_W'(needle_codes_reg);
            REG_NEEDLE_LENGTH: prdata = DATA_W'(needle_length_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/dna_needle_matcher.sv @@
// Top level of the DNA needle matcher: window registers, compare and result register.
// Instantiates dnm_cfg; uses types and functions from dnm_pkg.

// The matcher takes one 2-bit base word per clock cycle and searches the stream
// for the needle held in the configuration registers (up to 32 bases, first base
// in the low bits of needle_codes). Each accepted word is shifted into a base window
// and a break window in the first register stage; the second stage compares the
// whole window against the needle in parallel and loads the output register. A result
// word appears only when a match ends at the position or the position is the last of
// the stream; an accepted word passes the first-stage and output registers before
// m_valid, and the sustained rate is one base per cycle, limited only by the output
// handshake. hit_offset gives the start of the occurrence, hit_total the saturating
// match count so far; after the last base the windows and counters return to their
// reset state, so the next word starts a new stream. Positions within a needle length
// of the stream start and any window holding a break never match. Configuration
// writes must only be made while the block is idle.

module dna_needle_matcher import dnm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // Base stream
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BASE_W-1:0] s_base_code,
    input  logic              s_is_break,
    input  logic              s_last_base,
    // Results
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit_valid,
    output logic [CNT_W-1:0]  m_hit_offset,
    output logic              m_stream_done,
    output logic [CNT_W-1:0]  m_hit_total
);

    match_cfg_t cfg;

    dnm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // First stage: the windows after the shift, and the position of that base.
    logic                  s1_valid_reg, s1_valid_next;
    logic                  restart_reg, restart_next;
    logic [WIN_W-1:0]      win_reg, win_next;
    logic [MAX_NEEDLE-1:0] brk_reg, brk_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic                  s1_last_reg, s1_last_next;

    // Second stage: per-stream hit count and the output word.
    logic                  m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]      mcount_reg, mcount_next;
    logic                  hit_valid_reg, hit_valid_next;
    logic [CNT_W-1:0]      hit_offset_reg, hit_offset_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      total_reg, total_next;

    logic                  s_accept;
    logic                  s1_adv;
    logic                  hit;
    logic [CNT_W-1:0]      count_new;
    logic [WIN_W-1:0]      src_win;
    logic [MAX_NEEDLE-1:0] src_brk;

    // The second stage moves on when the output register is free or being emptied.
    assign s1_adv   = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready  = ~s1_valid_reg | s1_adv;
    assign s_accept = s_valid & s_ready;

    // After the last base of a stream the next word shifts into fresh windows.
    always_comb begin
        src_win = restart_reg ? '0 : win_reg;
        src_brk = restart_reg ? '1 : brk_reg;

        s1_valid_next = s1_valid_reg;
        restart_next  = restart_reg;
        win_next      = win_reg;
        brk_next      = brk_reg;
        pos_next      = pos_reg;
        s1_last_next  = s1_last_reg;

        if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        if (s_accept) begin
            s1_valid_next = 1'b1;
            restart_next  = s_last_base;
            win_next      = WIN_W'({src_win, s_base_code});
            brk_next      = MAX_NEEDLE'({src_brk, s_is_break});
            s1_last_next  = s_last_base;
            if (restart_reg) begin
                pos_next = '0;
            end else if (pos_reg != CNT_MAX) begin
                pos_next = pos_reg + CNT_W'(1);
            end
        end
    end

    // Parallel compare of the newest needle-length window slots against the aligned needle.
    assign hit = cfg.len_ok
               & ((brk_reg & cfg.brk_mask) == '0)
               & (((win_reg ^ cfg.target) & cfg.base_mask) == '0);

    assign count_new = (hit && mcount_reg != CNT_MAX) ? mcount_reg + CNT_W'(1) : mcount_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        mcount_next     = mcount_reg;
        hit_valid_next  = hit_valid_reg;
        hit_offset_next = hit_offset_reg;
        done_next       = done_reg;
        total_next      = total_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_adv) begin
            mcount_next = s1_last_reg ? '0 : count_new;
            if (hit || s1_last_reg) begin
                m_valid_next    = 1'b1;
                hit_valid_next  = hit;
                // On a hit the length is at least one, so len-1 never wraps.
                hit_offset_next = hit ? pos_reg - CNT_W'(cfg.len - LEN_W'(1)) : '0;
                done_next       = s1_last_reg;
                total_next      = count_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            restart_reg  <= 1'b1;
            m_valid_reg  <= 1'b0;
            mcount_reg   <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            restart_reg  <= restart_next;
            m_valid_reg  <= m_valid_next;
            mcount_reg   <= mcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg        <= win_next;
        brk_reg        <= brk_next;
        pos_reg        <= pos_next;
        s1_last_reg    <= s1_last_next;
        hit_valid_reg  <= hit_valid_next;
        hit_offset_reg <= hit_offset_next;
        done_reg       <= done_next;
        total_reg      <= total_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit_valid   = hit_valid_reg;
    assign m_hit_offset  = hit_offset_reg;
    assign m_stream_done = done_reg;
    assign m_hit_total   = total_reg;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for dna_needle_matcher: APB needle setup, base stream and result check.
// Depends on dnm_pkg, dnm_cfg and the dna_needle_matcher RTL; needs no other file.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dnm_pkg::*;

    // Cycles allowed for a word still in the pipeline once nothing is expected.
    localparam int LAT_PAD   = 8;
    // Cycles without any handshake or register access before the run is abandoned.
    localparam int QUIET_MAX = 3000;

    // One result word, in the order of the result ports.
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] offset;
        logic             done;
        logic [CNT_W-1:0] total;
    } hit_word_t;

    // Predicts the matcher: mirrors the needle registers, the two shift windows and the
    // saturating counters, and keeps the result words still owed by the block.
    class needle_hit_tracker;
        logic [WIN_W-1:0]      needle_codes;
        logic [LEN_W-1:0]      needle_len;
        logic [WIN_W-1:0]      base_win;
        logic [MAX_NEEDLE-1:0] brk_win;
        logic [CNT_W-1:0]      pos_cnt;
        logic [CNT_W-1:0]      match_cnt;
        hit_word_t             expected_hits[$];
        int unsigned           errors;
        int unsigned           bases;
        int unsigned           hits;
        int unsigned           streams;

        function new();
            needle_codes = '0;
            needle_len   = LEN_W'(1);
            errors       = 0;
            bases        = 0;
            hits         = 0;
            streams      = 0;
            restart();
        endfunction

        function void restart();
            base_win  = '0;
            brk_win   = '1;
            pos_cnt   = '0;
            match_cnt = '0;
        endfunction

        // True when the newest needle_len window slots hold the needle and no break.
        function bit window_hit();
            int unsigned n;
            n = needle_len;
            if (n == 0 || n > MAX_NEEDLE) return 1'b0;
            for (int i = 0; i < n; i++) begin
                if (brk_win[i]) return 1'b0;
            end
            for (int j = 0; j < n; j++) begin
                if (needle_codes[2*j +: 2] != base_win[2*(n-1-j) +: 2]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Notes one accepted base word and queues the result word it causes, if any.
        function void take_base(logic [BASE_W-1:0] code, logic brk, logic last);
            hit_word_t w;
            base_win = {base_win[WIN_W-BASE_W-1:0], code};
            brk_win  = {brk_win[MAX_NEEDLE-2:0], brk};
            w        = '0;
            w.hit    = window_hit();
            if (w.hit) begin
                w.offset = pos_cnt - CNT_W'(needle_len - 1);
                if (match_cnt != CNT_MAX) match_cnt++;
                hits++;
            end
            if (pos_cnt != CNT_MAX) pos_cnt++;
            bases++;
            w.done  = last;
            w.total = match_cnt;
            if (w.hit || last) expected_hits.push_back(w);
            if (last) begin
                streams++;
                restart();
            end
        endfunction

        // Compares one accepted result word with the oldest expected one.
        function void check_word(hit_word_t got);
            hit_word_t exp_w;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result word, got hit %0b offset %0d done %0b total %0d",
                         $time, got.hit, got.offset, got.done, got.total);
                errors++;
                return;
            end
            exp_w = expected_hits.pop_front();
            if (got.hit !== exp_w.hit) begin
                $display("%0t: hit_valid mismatch, expected %0b, got %0b",
                         $time, exp_w.hit, got.hit);
                errors++;
            end
            if (got.offset !== exp_w.offset) begin
                $display("%0t: hit_offset mismatch, expected %0d, got %0d",
                         $time, exp_w.offset, got.offset);
                errors++;
            end
            if (got.done !== exp_w.done) begin
                $display("%0t: stream_done mismatch, expected %0b, got %0b",
                         $time, exp_w.done, got.done);
                errors++;
            end
            if (got.total !== exp_w.total) begin
                $display("%0t: hit_total mismatch, expected %0d, got %0d",
                         $time, exp_w.total, got.total);
                errors++;
            end
        endfunction
    endclass

    // Clock, reset and every block input start at a known value.
    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic [BASE_W-1:0] s_base_code   = '0;
    logic              s_is_break    = 1'b0;
    logic              s_last_base   = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_hit_valid;
    logic [CNT_W-1:0]  m_hit_offset;
    logic              m_stream_done;
    logic [CNT_W-1:0]  m_hit_total;

    // Idle percentages of the sender and the receiver, changed between phases.
    int unsigned       tx_idle_pct   = 10;
    int unsigned       rx_idle_pct   = 82;
    // Needle as last programmed, used to plant occurrences in the random streams.
    logic [WIN_W-1:0]  cur_codes     = '0;
    logic [LEN_W-1:0]  cur_len       = LEN_W'(1);
    int unsigned       quiet_cycles  = 0;

    needle_hit_tracker tracker;

    always #5 aclk = ~aclk;

    dna_needle_matcher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_code   (s_base_code),
        .s_is_break    (s_is_break),
        .s_last_base   (s_last_base),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit_valid   (m_hit_valid),
        .m_hit_offset  (m_hit_offset),
        .m_stream_done (m_stream_done),
        .m_hit_total   (m_hit_total)
    );

    // Result side: the values read here are the ones present before the edge, so a word
    // counts as accepted exactly when the block sees valid and ready together. m_ready
    // is then redrawn for the next cycle according to the current receiver idle rate.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_word('{hit: m_hit_valid, offset: m_hit_offset,
                                 done: m_stream_done, total: m_hit_total});
        end
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog: any handshake or register access counts as progress.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One APB write: setup cycle, then access cycle; the register takes the data at the
    // edge that ends the access phase. The task starts on a fresh edge so that back to
    // back writes never drive psel twice within one time step.
    task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reprograms the needle. The stream is held off until every expected result word
    // has been taken and the pipeline has had time to settle, since a base that makes
    // no result may still be in flight when the last expected word leaves.
    task automatic program_needle(logic [WIN_W-1:0] codes, logic [LEN_W-1:0] len);
        s_valid <= 1'b0;
        while (tracker.expected_hits.size() != 0) @(posedge aclk);
        repeat (LAT_PAD) @(posedge aclk);
        reg_write(REG_NEEDLE_CODES, codes);
        reg_write(REG_NEEDLE_LENGTH, DATA_W'(len));
        tracker.needle_codes = codes;
        tracker.needle_len   = len;
        cur_codes            = codes;
        cur_len              = len;
        // The new needle reaches the compare stage through the registered compare setup.
        repeat (2) @(posedge aclk);
    endtask

    // Sends one base word. Idle cycles are inserted before it at the sender idle rate;
    // when there are none, valid simply stays high into the next word.
    task automatic send_base(logic [BASE_W-1:0] code, logic brk, logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_base_code <= code;
        s_is_break  <= brk;
        s_last_base <= last;
        do @(posedge aclk); while (!s_ready);
        tracker.take_base(code, brk, last);
    endtask

    // Random streams under the current needle. Most streams carry planted copies of the
    // needle (some with one base changed) among random bases, with rare breaks; stream
    // lengths cluster around the needle length so short streams occur, and one stream
    // in ten is long. A stream always runs to its last base, even past the quota.
    task automatic run_segment(int unsigned quota);
        int unsigned     sent;
        int unsigned     slen;
        int unsigned     eff;
        logic [BASE_W-1:0] plan[$];
        logic [BASE_W-1:0] code;
        logic            brk;
        sent = 0;
        eff  = (cur_len > MAX_NEEDLE) ? MAX_NEEDLE : cur_len;
        while (sent < quota) begin
            if ($urandom_range(9) == 0) begin
                slen = $urandom_range(60, 300);
            end else begin
                slen = $urandom_range(1, 2 * eff + 8);
            end
            plan.delete();
            for (int i = 0; i < slen; i++) begin
                if (plan.size() == 0 && eff != 0 && $urandom_range(99) < 35) begin
                    for (int j = 0; j < eff; j++) plan.push_back(cur_codes[2*j +: 2]);
                    if ($urandom_range(4) == 0) begin
                        plan[$urandom_range(eff - 1)] = BASE_W'($urandom);
                    end
                end
                code = (plan.size() != 0) ? plan.pop_front() : BASE_W'($urandom);
                brk  = ($urandom_range(99) < 3);
                send_base(code, brk, i == slen - 1);
                sent++;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset needle, a single A.
        send_base(2'd0, 1'b0, 1'b0);    // hit at offset 0
        send_base(2'd3, 1'b0, 1'b0);    // T: no word
        send_base(2'd0, 1'b1, 1'b0);    // A flagged as a break: no hit
        send_base(2'd0, 1'b0, 1'b1);    // hit on the last base, total 2
        send_base(2'd3, 1'b0, 1'b1);    // last base alone, no hit
        send_base(2'd0, 1'b1, 1'b1);    // last base that is a break

        // Needle ACGT: a stream shorter than the needle, then overlapping-free repeats
        // at offsets 0 and 5, then a break inside an otherwise matching window.
        program_needle(64'hE4, 6'd4);
        send_base(2'd0, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd2, 1'b0, 1'b1);
        send_base(2'd0, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd2, 1'b0, 1'b0);
        send_base(2'd3, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd0, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd2, 1'b0, 1'b0);
        send_base(2'd3, 1'b0, 1'b1);
        send_base(2'd0, 1'b0, 1'b0);
        send_base(2'd1, 1'b0, 1'b0);
        send_base(2'd2, 1'b1, 1'b0);
        send_base(2'd3, 1'b0, 1'b1);

        // Random part: eight needle settings, including the longest needle of all T and
        // of all A, a single base, and lengths that can never match (zero, just above
        // the maximum, and the largest the register holds). The idle pattern moves from
        // a mostly stalled receiver to a mostly idle sender and finally to full rate.
        for (int seg = 0; seg < 8; seg++) begin
            case (seg)
                0: program_needle({$urandom, $urandom}, 6'd3);
                1: program_needle('1, 6'd32);
                2: program_needle('0, 6'd32);
                3: program_needle({$urandom, $urandom}, 6'd1);
                4: program_needle({$urandom, $urandom}, 6'd0);
                5: program_needle({$urandom, $urandom}, 6'd33);
                6: program_needle({$urandom, $urandom}, 6'd63);
                default: program_needle({$urandom, $urandom},
                                        LEN_W'($urandom_range(1, MAX_NEEDLE)));
            endcase
            if (seg < 3) begin
                tx_idle_pct = 10;
                rx_idle_pct = 82;
            end else if (seg < 6) begin
                tx_idle_pct = 82;
                rx_idle_pct = 10;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            run_segment(150);
        end

        // Drain: wait for every owed word, then give a stray word time to show up.
        s_valid <= 1'b0;
        while (tracker.expected_hits.size() != 0) @(posedge aclk);
        repeat (LAT_PAD) @(posedge aclk);

        $display("Covered %0d bases in %0d streams with %0d hits over 10 needle settings,",
                 tracker.bases, tracker.streams, tracker.hits);
        $display("including unmatchable lengths, breaks and short streams; %0d mismatches.",
                 tracker.errors);
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
